### sv/ffea_pkg.sv
// Shared types, codes and constants of the first-fit extent allocator.
package ffea_pkg;

    localparam int FFEA_MAX_EXTENTS = 64;

    localparam int ADDR_W  = 32;
    localparam int OWNER_W = 30;

    // Operation codes carried on the opcode field.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_OVERFLOW = 2'd2
    } stat_t;

    // One table entry as stored in the extent memory.
    typedef struct packed {
        logic [ADDR_W-1:0]  end_addr;
        logic [OWNER_W-1:0] owner;
        logic               is_free;
    } extent_t;

    localparam int EXTENT_W = $bits(extent_t);

    // Source of the data written to the extent memory.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLAIM,
        WR_FREE,
        WR_SHIFT,
        WR_SPLIT,
        WR_APPEND
    } wr_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    k_clr;
        logic    k_inc;
        logic    start_upd;
        logic    len_sub;
        logic    rd_k;
        logic    rd_jm1;
        wr_sel_t wr_sel;
        logic    j_init;
        logic    j_dec;
        logic    cnt_inc;
        logic    cnt_clr;
        logic    res_hit;
        logic    set_stat;
        stat_t   stat_code;
        logic    out_load;
    } ffea_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic len_zero;
        logic k_at_end;
        logic full;
        logic is_free;
        logic size_gt_len;
        logic size_eq_len;
        logic owner_match;
        logic pos_below;
        logic j_at_k;
        logic ovf;
        logic out_busy;
    } ffea_stat_t;

endpackage

### sv/ffea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/ffea_datapath.sv
// Datapath of the extent allocator: operand registers, extent memory and result registers.
module ffea_datapath #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffea_pkg::ffea_cmd_t         cmd,
    output ffea_pkg::ffea_stat_t        st,
    input  logic [1:0]                  opcode,
    input  logic [ffea_pkg::OWNER_W-1:0] file_id,
    input  logic [ffea_pkg::ADDR_W-1:0] length,
    input  logic [ffea_pkg::ADDR_W-1:0] position,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ffea_pkg::OWNER_W-1:0] owner,
    output logic                        owner_found,
    output logic [1:0]                  status
);
    import ffea_pkg::*;

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_EXTENTS);

    logic [1:0]         op_reg;
    logic [OWNER_W-1:0] fid_reg;
    logic [ADDR_W-1:0]  len_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic [ADDR_W-1:0]  tail_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      cnt_reg;
    logic [IW-1:0]      j_reg;
    logic [OWNER_W-1:0] who_reg;
    logic               found_reg;
    stat_t              stat_reg;
    logic               out_valid_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic               owner_found_reg;
    logic [1:0]         status_reg;

    logic [ADDR_W-1:0]  size;
    logic [ADDR_W:0]    app_sum;
    logic [ADDR_W-1:0]  last_end;
    extent_t            rd_ext;
    logic [EXTENT_W-1:0] rdata;
    extent_t            wr_ext;
    logic [IW-1:0]      waddr;
    logic [IW-1:0]      raddr;
    logic               we;

    // Extent table storage.
    ffea_ram #(
        .WIDTH (EXTENT_W),
        .DEPTH (MAX_EXTENTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_ext),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_ext = extent_t'(rdata);

    // Sizes, comparisons and the append end address.
    always_comb
    begin
        size     = rd_ext.end_addr - start_reg;
        last_end = (cnt_reg == '0) ? '0 : tail_reg;
        app_sum  = {1'b0, last_end} + {1'b0, len_reg};
    end

    // Status toward the controller.
    always_comb
    begin
        st.op          = op_t'(op_reg);
        st.len_zero    = (len_reg == '0);
        st.k_at_end    = (k_reg >= cnt_reg);
        st.full        = (cnt_reg >= MaxCnt);
        st.is_free     = rd_ext.is_free;
        st.size_gt_len = (size > len_reg);
        st.size_eq_len = (size == len_reg);
        st.owner_match = (rd_ext.owner == fid_reg);
        st.pos_below   = (pos_reg < rd_ext.end_addr);
        st.j_at_k      = (j_reg == k_reg[IW-1:0]);
        st.ovf         = app_sum[ADDR_W];
        st.out_busy    = out_valid_reg && out_stall;
    end

    // Memory write address and data selection.
    always_comb
    begin
        we     = 1'b1;
        waddr  = k_reg[IW-1:0];
        wr_ext = rd_ext;
        case (cmd.wr_sel)
            WR_CLAIM:
            begin
                wr_ext = '{end_addr: rd_ext.end_addr, owner: fid_reg, is_free: 1'b0};
            end
            WR_FREE:
            begin
                wr_ext = '{end_addr: rd_ext.end_addr, owner: rd_ext.owner, is_free: 1'b1};
            end
            WR_SHIFT:
            begin
                waddr = j_reg;
            end
            WR_SPLIT:
            begin
                wr_ext = '{end_addr: start_reg + len_reg, owner: fid_reg, is_free: 1'b0};
            end
            WR_APPEND:
            begin
                waddr  = cnt_reg[IW-1:0];
                wr_ext = '{end_addr: app_sum[ADDR_W-1:0], owner: fid_reg, is_free: 1'b0};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Read address: the scan index or the entry below the shift slot.
    assign raddr = cmd.rd_jm1 ? (j_reg - IW'(1)) : k_reg[IW-1:0];

    // Operand, walk and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg  <= '0;
                tail_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.wr_sel == WR_APPEND)
            begin
                tail_reg <= app_sum[ADDR_W-1:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            fid_reg   <= file_id;
            len_reg   <= length;
            pos_reg   <= position;
            who_reg   <= '0;
            found_reg <= 1'b0;
            stat_reg  <= STAT_OK;
        end
        if (cmd.k_clr)
        begin
            k_reg     <= '0;
            start_reg <= '0;
        end
        if (cmd.k_inc)
        begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.start_upd)
        begin
            start_reg <= rd_ext.end_addr;
        end
        if (cmd.len_sub)
        begin
            len_reg <= len_reg - size;
        end
        if (cmd.j_init)
        begin
            j_reg <= cnt_reg[IW-1:0];
        end
        else if (cmd.j_dec)
        begin
            j_reg <= j_reg - IW'(1);
        end
        if (cmd.res_hit)
        begin
            who_reg   <= rd_ext.owner;
            found_reg <= 1'b1;
        end
        if (cmd.set_stat)
        begin
            stat_reg <= cmd.stat_code;
        end
        if (cmd.out_load)
        begin
            owner_reg       <= who_reg;
            owner_found_reg <= found_reg;
            status_reg      <= stat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign owner       = owner_reg;
    assign owner_found = owner_found_reg;
    assign status      = status_reg;

    // The table never holds more entries than it has room for.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MaxCnt)
        else $error("extent count above table size");

    // A new entry is only added while there is room.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (cnt_reg < MaxCnt))
        else $error("entry added to a full table");

    // An append never wraps the address space.
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_APPEND) |-> !app_sum[ADDR_W])
        else $error("append past the last sector address");

    // A new result never overwrites one that is still waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

endmodule

### sv/ffea_ctrl.sv
// Controller state machine of the extent allocator.
module ffea_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ffea_pkg::ffea_stat_t st,
    output ffea_pkg::ffea_cmd_t  cmd
);
    import ffea_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        cmd.stat_code = STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.op)
                    OP_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_DONE;
                    end
                    OP_WRITE:
                    begin
                        state_next = st.len_zero ? S_DONE : S_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = S_SCAN_RD;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (st.k_at_end)
                begin
                    state_next = (st.op == OP_WRITE) ? S_APPEND : S_DONE;
                end
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                case (st.op)
                    OP_WRITE:
                    begin
                        if (st.is_free && st.size_gt_len)
                        begin
                            // The write ends inside this free extent: split it.
                            if (st.full)
                            begin
                                cmd.set_stat  = 1'b1;
                                cmd.stat_code = STAT_FULL;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                cmd.j_init = 1'b1;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        else if (st.is_free && st.size_eq_len)
                        begin
                            cmd.wr_sel  = WR_CLAIM;
                            cmd.len_sub = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            if (st.is_free)
                            begin
                                cmd.wr_sel  = WR_CLAIM;
                                cmd.len_sub = 1'b1;
                            end
                            cmd.start_upd = 1'b1;
                            cmd.k_inc     = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!st.is_free && st.owner_match)
                        begin
                            cmd.wr_sel = WR_FREE;
                        end
                        cmd.k_inc  = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    default:
                    begin
                        // Sector read: stop at the first extent ending above it.
                        if (st.pos_below)
                        begin
                            cmd.res_hit = !st.is_free;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.k_inc  = 1'b1;
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (st.j_at_k)
                begin
                    cmd.wr_sel  = WR_SPLIT;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_jm1 = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_sel = WR_SHIFT;
                cmd.j_dec  = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_APPEND:
            begin
                if (st.full)
                begin
                    cmd.set_stat  = 1'b1;
                    cmd.stat_code = STAT_FULL;
                end
                else if (st.ovf)
                begin
                    cmd.set_stat  = 1'b1;
                    cmd.stat_code = STAT_OVERFLOW;
                end
                else
                begin
                    cmd.wr_sel  = WR_APPEND;
                    cmd.cnt_inc = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator: controller, datapath and extent memory.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_stall    | opcode, file_id, length, position
//  out     | out_valid / out_stall  | owner, owner_found, status
//
// One item at a time.
// A walk visits the table entries one at a time (one memory read port, registered).
// A split moves each entry above the split point up by one slot, one entry at a time.
// Reset empties the table; the memory itself needs no clearing pass.
// A stalled result holds the block in its done state once the next result is ready, until taken.
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffea_pkg::FFEA_MAX_EXTENTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [ffea_pkg::OWNER_W-1:0] file_id,
    input  logic [ffea_pkg::ADDR_W-1:0]  length,
    input  logic [ffea_pkg::ADDR_W-1:0]  position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ffea_pkg::OWNER_W-1:0] owner,
    output logic                         owner_found,
    output logic [1:0]                   status
);
    import ffea_pkg::*;

    ffea_cmd_t  cmd;
    ffea_stat_t st;

    // Sequencer.
    ffea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Table walk, memory and result registers.
    ffea_datapath #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .opcode      (opcode),
        .file_id     (file_id),
        .length      (length),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .owner       (owner),
        .owner_found (owner_found),
        .status      (status)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for the first-fit extent allocator.
`timescale 1ns / 100ps

module testbench;
    import ffea_pkg::*;

    localparam int NUM_EXT     = FFEA_MAX_EXTENTS;
    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [OWNER_W-1:0]  file_id;
    logic [ADDR_W-1:0]   length;
    logic [ADDR_W-1:0]   position;
    logic                out_valid;
    logic                out_stall;
    logic [OWNER_W-1:0]  owner;
    logic                owner_found;
    logic [1:0]          status;

    // Expected result of one item.
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic               found;
        stat_t              status;
    } alloc_result_t;

    alloc_result_t pending_results[$];

    // Shadow copy of the extent table.
    logic [ADDR_W-1:0]  shadow_end   [NUM_EXT];
    logic [OWNER_W-1:0] shadow_owner [NUM_EXT];
    logic               shadow_free  [NUM_EXT];
    int                 shadow_count;

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  cycle_count;
    bit  quiet_mode;
    int  full_hits;
    int  ovf_hits;
    int  read_hits;

    first_fit_extent_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .file_id     (file_id),
        .length      (length),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .owner       (owner),
        .owner_found (owner_found),
        .status      (status)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Predicts a write and updates the shadow table.
    function automatic stat_t predict_write(logic [OWNER_W-1:0] fid, logic [ADDR_W-1:0] len);
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W:0]   sum;
        if (len == 0)
            return STAT_OK;
        start = '0;
        for (int k = 0; k < shadow_count; k++)
        begin
            if (shadow_free[k])
            begin
                size = shadow_end[k] - start;
                if (size > len)
                begin
                    if (shadow_count >= NUM_EXT)
                        return STAT_FULL;
                    for (int j = shadow_count; j > k; j--)
                    begin
                        shadow_end[j]   = shadow_end[j-1];
                        shadow_owner[j] = shadow_owner[j-1];
                        shadow_free[j]  = shadow_free[j-1];
                    end
                    shadow_end[k]   = start + len;
                    shadow_owner[k] = fid;
                    shadow_free[k]  = 1'b0;
                    shadow_count++;
                    return STAT_OK;
                end
                shadow_owner[k] = fid;
                shadow_free[k]  = 1'b0;
                len = len - size;
                if (len == 0)
                    return STAT_OK;
            end
            start = shadow_end[k];
        end
        if (shadow_count >= NUM_EXT)
            return STAT_FULL;
        last = (shadow_count > 0) ? shadow_end[shadow_count-1] : '0;
        sum = {1'b0, last} + {1'b0, len};
        if (sum[ADDR_W])
            return STAT_OVERFLOW;
        shadow_end[shadow_count]   = sum[ADDR_W-1:0];
        shadow_owner[shadow_count] = fid;
        shadow_free[shadow_count]  = 1'b0;
        shadow_count++;
        return STAT_OK;
    endfunction

    // Predicts the result of one item.
    function automatic alloc_result_t predict_item(op_t op, logic [OWNER_W-1:0] fid,
                                                   logic [ADDR_W-1:0] len,
                                                   logic [ADDR_W-1:0] pos);
        alloc_result_t r;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_WRITE:
                r.status = predict_write(fid, len);
            OP_DELETE:
                for (int k = 0; k < shadow_count; k++)
                    if (!shadow_free[k] && shadow_owner[k] == fid)
                        shadow_free[k] = 1'b1;
            OP_READ:
                for (int k = 0; k < shadow_count; k++)
                    if (pos < shadow_end[k])
                    begin
                        if (!shadow_free[k])
                        begin
                            r.owner = shadow_owner[k];
                            r.found = 1'b1;
                        end
                        break;
                    end
            default:
                shadow_count = 0;
        endcase
        return r;
    endfunction

    // Sends one item, with optional idle cycles in front.
    task automatic send_item(op_t op, logic [OWNER_W-1:0] fid,
                             logic [ADDR_W-1:0] len, logic [ADDR_W-1:0] pos);
        alloc_result_t r;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        r = predict_item(op, fid, len, pos);
        if (r.status == STAT_FULL)
            full_hits++;
        if (r.status == STAT_OVERFLOW)
            ovf_hits++;
        if (r.found)
            read_hits++;
        pending_results = {pending_results, r};
        in_valid <= 1'b1;
        opcode   <= op;
        file_id  <= fid;
        length   <= len;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Receiver stall bursts.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result owner=%h found=%b status=%0d",
                         $time, owner, owner_found, status);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (owner !== e.owner)
                begin
                    $display("%0t: owner expected %h actual %h", $time, e.owner, owner);
                    error_count++;
                end
                if (owner_found !== e.found)
                begin
                    $display("%0t: owner_found expected %b actual %b",
                             $time, e.found, owner_found);
                    error_count++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    error_count++;
                end
            end
        end
    end

    // Run timeout.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [OWNER_W-1:0] rand_fid(int span);
        return OWNER_W'($urandom_range(0, span));
    endfunction

    // Directed: extremes, every operation and each special case.
    task automatic test_directed();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_WRITE, 30'h3FFF_FFFF, '0, '0);
        send_item(OP_WRITE, 30'h3FFF_FFFF, 32'd10, '0);
        send_item(OP_WRITE, 30'h1555_5555, 32'd20, 32'hFFFF_FFFF);
        send_item(OP_READ, '0, '0, 32'd9);
        send_item(OP_READ, '0, '0, 32'd10);
        send_item(OP_READ, '0, '0, 32'd30);
        send_item(OP_READ, '0, '0, 32'hFFFF_FFFF);
        send_item(OP_DELETE, 30'h3FFF_FFFF, 32'hFFFF_FFFF, '0);
        send_item(OP_READ, '0, '0, 32'd3);
        send_item(OP_WRITE, 30'h2AAA_AAAA, 32'd4, 32'h5555_5555);
        send_item(OP_READ, '0, '0, 32'd5);
        send_item(OP_WRITE, 30'h0000_0007, 32'd30, '0);
        send_item(OP_WRITE, 30'h1, 32'hFFFF_FFFF, '0);
        send_item(OP_WRITE, 30'h2, 32'hFFFF_FF00, '0);
        send_item(OP_READ, '0, '0, 32'hAAAA_AAAA);
        send_item(OP_CLEAR, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 30'h3, 32'hFFFF_FFFF, '0);
        send_item(OP_READ, '0, '0, 32'hFFFF_FFFE);
        send_item(OP_CLEAR, '0, '0, '0);
        // Fill the table, then force a full table on both append and split.
        for (int i = 0; i < NUM_EXT; i++)
            send_item(OP_WRITE, OWNER_W'(i), 32'd2, '0);
        send_item(OP_WRITE, 30'h100, 32'd1, '0);
        send_item(OP_DELETE, 30'd5, '0, '0);
        send_item(OP_WRITE, 30'h101, 32'd1, '0);
        send_item(OP_WRITE, 30'h102, 32'd3, '0);
        send_item(OP_CLEAR, '0, '0, '0);
    endtask

    // Random: mostly small writes among few files, some extremes.
    task automatic test_random(int count);
        op_t               op;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] top;
        int                pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_WRITE;
            else if (pick < 60)
                op = OP_DELETE;
            else if (pick < 97)
                op = OP_READ;
            else
                op = OP_CLEAR;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = $urandom;
            else if (pick == 1)
                len = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else
                len = $urandom_range(0, 12);
            top = (shadow_count > 0) ? shadow_end[shadow_count-1] : '0;
            if ($urandom_range(0, 9) == 0 || top == 0)
                pos = $urandom;
            else
                pos = $urandom_range(0, top);
            send_item(op, ($urandom_range(0, 15) == 0) ? OWNER_W'($urandom) : rand_fid(7),
                      len, pos);
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_WRITE;
        file_id      = '0;
        length       = '0;
        position     = '0;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        cycle_count  = 0;
        quiet_mode   = 1'b0;
        full_hits    = 0;
        ovf_hits     = 0;
        read_hits    = 0;
        shadow_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(240);
        quiet_mode = 1'b1;
        test_random(80);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_EXT + 20) @(posedge clk);

        $display("Sent %0d items, checked %0d results.", items_sent, results_seen);
        $display("Full-table results %0d, overflow results %0d, owned reads %0d.",
                 full_hits, ovf_hits, read_hits);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
